### rtl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point transform composer package
// Shared types and constants for the composer's modules.
// ----------------------------------------------------------------------------
`default_nettype none
package fpt_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ROTX     = 3'd0,
        OP_ROTY     = 3'd1,
        OP_ROTZ     = 3'd2,
        OP_TRANS    = 3'd3,
        OP_SCALE    = 3'd4,
        OP_IDENT    = 3'd5,
        OP_READ     = 3'd6,
        OP_PACKED   = 3'd7
    } op_t;

    typedef enum logic {
        KIND_ELEM = 1'b0,
        KIND_MASK = 1'b1
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
        logic signed [DATA_W-1:0] value_c;
    } in_item_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] data;
        logic [IDX_W-1:0]         index;
        logic                     last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_op;
        logic              mac_en;
        logic              commit;
        logic              set_ident;
        logic [IDX_W-1:0]  elem;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [15:0]       diff_mask;
    } dp_stat_t;

endpackage
`default_nettype wire

### rtl/fpt_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface fpt_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/fixed_point_transform_composer.sv
// ----------------------------------------------------------------------------
// Fixed-point transform composer
// Folds elementary 4x4 transforms into a stored 16.16 matrix and reads it out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   op, value_a, value_b, value_c
//  out_ch    out  kind, data, index, last
//
// A transform command builds M, forms the sixteen elements of M*W one at a time
// on four multipliers, then copies the product into W. Identity sets W directly.
// Read-outs give one item per cycle while the output is taken. Reset sets W to
// identity at once. A stalled output holds its item and blocks further input.
`default_nettype none
module fixed_point_transform_composer #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpt_if.sink       in_ch,
    fpt_if.source     out_ch
);
    fpt_pkg::dp_cmd_t                  cmd;
    fpt_pkg::dp_stat_t                 stat;
    fpt_pkg::in_item_t                 item;
    logic signed [fpt_pkg::DATA_W-1:0] elem_data;

    fpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .item      (item),
        .stat      (stat),
        .elem_data (elem_data)
    );

    fpt_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .stat      (stat),
        .elem_data (elem_data)
    );
endmodule
`default_nettype wire

### rtl/fpt_datapath.sv
// ----------------------------------------------------------------------------
// Composer datapath
// Holds W and the scratch product; four multipliers form one element of
// M*W per cycle, and the scratch is copied back into W on commit.
// ----------------------------------------------------------------------------
`default_nettype none
module fpt_datapath #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fpt_pkg::dp_cmd_t               cmd,
    input  wire fpt_pkg::in_item_t              item,
    output fpt_pkg::dp_stat_t                   stat,
    output logic signed [fpt_pkg::DATA_W-1:0]   elem_data
);
    localparam int unsigned W = fpt_pkg::DATA_W;
    localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

    logic [W-1:0] w_reg [16];
    logic [W-1:0] p_reg [16];
    logic [W-1:0] m_reg [16];
    logic [W-1:0] m_next [16];
    logic [W-1:0] mrow [4];
    logic [W-1:0] wcol [4];
    logic signed [2*W-1:0] prod [4];
    logic [W-1:0] term [4];
    logic [W-1:0] acc;
    logic [W-1:0] nb;
    logic [1:0]   row;
    logic [1:0]   col;

    function automatic logic [W-1:0] ident(input int unsigned n);
        return ((n / 4) == (n % 4)) ? ONE : '0;
    endfunction

    assign nb  = '0 - item.value_b;
    assign row = cmd.elem[3:2];
    assign col = cmd.elem[1:0];

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            m_next[n] = ident(n);
        end
        case (fpt_pkg::op_t'(item.op))
            fpt_pkg::OP_ROTX:
            begin
                m_next[5] = item.value_a; m_next[6] = item.value_b;
                m_next[9] = nb;           m_next[10] = item.value_a;
            end
            fpt_pkg::OP_ROTY:
            begin
                m_next[0] = item.value_a; m_next[2] = nb;
                m_next[8] = item.value_b; m_next[10] = item.value_a;
            end
            fpt_pkg::OP_ROTZ:
            begin
                m_next[0] = item.value_a; m_next[1] = item.value_b;
                m_next[4] = nb;           m_next[5] = item.value_a;
            end
            fpt_pkg::OP_TRANS:
            begin
                m_next[3] = item.value_a; m_next[7] = item.value_b;
                m_next[11] = item.value_c;
            end
            fpt_pkg::OP_SCALE:
            begin
                m_next[0] = item.value_a; m_next[5] = item.value_b;
                m_next[10] = item.value_c;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            mrow[k] = m_reg[{row, 2'(k)}];
            wcol[k] = w_reg[{2'(k), col}];
            prod[k] = $signed(mrow[k]) * $signed(wcol[k]);
            // Division by 2^F truncating toward zero: bias negatives first.
            term[k] = W'((prod[k] + (prod[k][2*W-1] ? ((2*W)'(1) << FRACTION_BITS)
                          - (2*W)'(1) : '0)) >>> FRACTION_BITS);
            acc = acc + term[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            m_reg <= m_next;
        end
        if (cmd.mac_en)
        begin
            p_reg[cmd.elem] <= acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 16; n++)
            begin
                w_reg[n] <= ident(n);
            end
        end
        else if (cmd.set_ident)
        begin
            for (int n = 0; n < 16; n++)
            begin
                w_reg[n] <= ident(n);
            end
        end
        else if (cmd.commit)
        begin
            w_reg <= p_reg;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            stat.diff_mask[15-n] = (w_reg[n] != ident(n));
        end
    end

    assign elem_data = w_reg[cmd.elem];
endmodule
`default_nettype wire

### rtl/fpt_ctrl.sv
// ----------------------------------------------------------------------------
// Composer controller
// Sequences the element cycles of a product and the read-out streams.
// ----------------------------------------------------------------------------
`default_nettype none
module fpt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    fpt_if.sink                                in_ch,
    fpt_if.source                              out_ch,
    output fpt_pkg::dp_cmd_t                   cmd,
    output fpt_pkg::in_item_t                  item,
    input  wire fpt_pkg::dp_stat_t             stat,
    input  wire logic signed [fpt_pkg::DATA_W-1:0] elem_data
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MAC    = 5'b00010,
        ST_COMMIT = 5'b00100,
        ST_MASK   = 5'b01000,
        ST_STREAM = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [15:0]            sel_reg, sel_next;
    fpt_pkg::in_item_t      item_reg;
    fpt_pkg::out_item_t     out_reg, out_next;
    logic                   ovalid_reg, ovalid_next;
    logic                   accept;
    logic                   slot_free;
    logic [15:0]            m;
    logic [3:0]             first_idx;
    logic                   found;
    logic [15:0]            rest;

    assign slot_free    = !ovalid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = out_reg;
    assign item         = accept ? in_ch.payload : item_reg;

    // Lowest set position in sel_reg, where bit 15 is element 0.
    always_comb
    begin
        found     = 1'b0;
        first_idx = '0;
        for (int n = 15; n >= 0; n--)
        begin
            if (sel_reg[15-n])
            begin
                found     = 1'b1;
                first_idx = 4'(n);
            end
        end
        rest = sel_reg & ~(16'h8000 >> first_idx);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        m           = stat.diff_mask;
        cmd         = '0;
        cmd.elem    = cnt_reg[3:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    case (fpt_pkg::op_t'(in_ch.payload.op))
                        fpt_pkg::OP_IDENT:  cmd.set_ident = 1'b1;
                        fpt_pkg::OP_READ:
                        begin
                            sel_next   = 16'hFFFF;
                            state_next = ST_STREAM;
                        end
                        fpt_pkg::OP_PACKED:
                        begin
                            sel_next              = m;
                            out_next.kind         = fpt_pkg::KIND_MASK;
                            out_next.data         = {16'h0, m};
                            out_next.index        = '0;
                            out_next.last         = (m == '0);
                            ovalid_next           = 1'b1;
                            state_next            = (m == '0) ? ST_IDLE : ST_STREAM;
                        end
                        default:
                        begin
                            cmd.load_op = 1'b1;
                            state_next  = ST_MAC;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_STREAM:
            begin
                cmd.elem = first_idx;
                if (slot_free)
                begin
                    out_next.kind  = fpt_pkg::KIND_ELEM;
                    out_next.data  = elem_data;
                    out_next.index = first_idx;
                    out_next.last  = (rest == '0);
                    ovalid_next    = 1'b1;
                    sel_next       = rest;
                    if (rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg <= in_ch.payload;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && cnt_reg == 5'd15) |=> state_reg == ST_COMMIT)
        else $error("product did not commit after sixteen elements");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMMIT |=> state_reg == ST_IDLE)
        else $error("commit not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM && found == 1'b0) |-> 1'b0)
        else $error("stream state with nothing left to send");
endmodule
`default_nettype wire
